// ----- src/dmrp_pkg.sv -----
`default_nettype none
package dmrp_pkg;

	// Parse phases.
	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_NAMELEN = 3'd1;
	localparam logic [2:0] PH_LABEL   = 3'd2;
	localparam logic [2:0] PH_POINTER = 3'd3;
	localparam logic [2:0] PH_FIXED   = 3'd4;
	localparam logic [2:0] PH_RDATA   = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;

	// Result kinds.
	localparam logic [2:0] KIND_QUESTION   = 3'd0;
	localparam logic [2:0] KIND_END_OK     = 3'd4;
	localparam logic [2:0] KIND_END_TRUNC  = 3'd5;

	localparam logic [7:0]  POINTER_MIN  = 8'b11000000;
	localparam logic [15:0] CLASS_MASK   = 16'b0111111111111111;
	localparam logic [15:0] CLASS_TOP    = 16'b1000000000000000;

	localparam int HEADER_BYTES   = 12;
	localparam int QUESTION_BYTES = 4;
	localparam int RECORD_BYTES   = 10;

	// Result queue.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] message_id;
		logic [15:0] message_flags;
		logic [15:0] record_type;
		logic [14:0] record_class;
		logic        class_top_bit;
		logic [31:0] time_to_live;
		logic [15:0] rdata_length;
		logic        last;
	} out_t;

endpackage
`default_nettype wire

// ----- src/dns_message_record_parser_core.sv -----
// Channel  | Direction | Handshake               | Payload
// msg      | in        | msg_valid / msg_stall   | dmrp_pkg::in_t  (one message byte)
// res      | out       | res_valid / res_stall   | dmrp_pkg::out_t (one record or end result)
//
// One byte is accepted per cycle while msg_stall is low; its state updates in that cycle.
// Results enter a four-entry queue and leave it one per cycle when res_stall is low.
// A byte that completes a record and ends the message pushes two results.
// msg_stall rises while the queue holds three or more results.
// arst_n clears the parse state and empties the queue.
`default_nettype none
module dns_message_record_parser_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           msg_valid,
	output logic                msg_stall,
	input  wire dmrp_pkg::in_t  msg,
	output logic                res_valid,
	input  wire logic           res_stall,
	output dmrp_pkg::out_t      res
);

	logic [2:0]  phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [2:0]  sec_q, sec_d;
	logic [15:0] counts_q [4];
	logic [15:0] counts_d [4];
	logic [15:0] id_q, id_d;
	logic [15:0] flags_q, flags_d;
	logic [15:0] type_q, type_d;
	logic [15:0] class_q, class_d;
	logic [31:0] ttl_q, ttl_d;
	logic [15:0] len_q, len_d;

	logic           accept;
	logic           rec_v, item_done, seek;
	logic           question;
	logic [1:0]     hdr_k;
	logic [2:0]     sec_n;
	logic [7:0]     b;
	dmrp_pkg::out_t rec_res, end_res;
	logic           push0_v, push1_v;
	dmrp_pkg::out_t push0, push1;

	dmrp_pkg::out_t                 fifo_q [dmrp_pkg::QDEPTH];
	logic [dmrp_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [dmrp_pkg::QCNT_W-1:0]    count_q;
	logic                           pop;

	assign accept    = msg_valid && !msg_stall;
	assign b         = msg.data_byte;
	assign question  = (sec_q == 3'd0);
	assign hdr_k     = 2'((cnt_q - 16'd4) >> 1);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		sec_d     = sec_q;
		counts_d  = counts_q;
		id_d      = id_q;
		flags_d   = flags_q;
		type_d    = type_q;
		class_d   = class_q;
		ttl_d     = ttl_q;
		len_d     = len_q;
		rec_v     = 1'b0;
		item_done = 1'b0;
		seek      = 1'b0;
		sec_n     = 3'd4;
		rec_res   = '0;
		end_res   = '0;

		unique case (phase_q)
			dmrp_pkg::PH_HEADER: begin
				if (cnt_q < 16'd2) begin
					id_d = {id_q[7:0], b};
				end else if (cnt_q < 16'd4) begin
					flags_d = {flags_q[7:0], b};
				end else if (cnt_q < 16'(dmrp_pkg::HEADER_BYTES)) begin
					counts_d[hdr_k] = {counts_q[hdr_k][7:0], b};
				end
				cnt_d = cnt_q + 16'd1;
				if (cnt_d >= 16'(dmrp_pkg::HEADER_BYTES)) begin
					cnt_d = '0;
					sec_d = '0;
					seek  = 1'b1;
				end
			end
			dmrp_pkg::PH_NAMELEN: begin
				if (b == 8'd0) begin
					phase_d = dmrp_pkg::PH_FIXED;
					cnt_d   = '0;
				end else if (b >= dmrp_pkg::POINTER_MIN) begin
					phase_d = dmrp_pkg::PH_POINTER;
				end else begin
					phase_d = dmrp_pkg::PH_LABEL;
					cnt_d   = {8'd0, b};
				end
			end
			dmrp_pkg::PH_LABEL: begin
				if (cnt_q != 16'd0) begin
					cnt_d = cnt_q - 16'd1;
				end
				if (cnt_d == 16'd0) begin
					phase_d = dmrp_pkg::PH_NAMELEN;
				end
			end
			dmrp_pkg::PH_POINTER: begin
				phase_d = dmrp_pkg::PH_FIXED;
				cnt_d   = '0;
			end
			dmrp_pkg::PH_FIXED: begin
				if (cnt_q < 16'd2) begin
					type_d = {type_q[7:0], b};
				end else if (cnt_q < 16'd4) begin
					class_d = {class_q[7:0], b};
				end else if (cnt_q < 16'd8) begin
					ttl_d = {ttl_q[23:0], b};
				end else begin
					len_d = {len_q[7:0], b};
				end
				cnt_d = cnt_q + 16'd1;
				rec_res.message_id    = id_q;
				rec_res.message_flags = flags_q;
				rec_res.record_type   = type_d;
				rec_res.record_class  = 15'(class_d & dmrp_pkg::CLASS_MASK);
				rec_res.class_top_bit = |(class_d & dmrp_pkg::CLASS_TOP);
				if (question && cnt_d >= 16'(dmrp_pkg::QUESTION_BYTES)) begin
					rec_v        = 1'b1;
					rec_res.kind = dmrp_pkg::KIND_QUESTION;
					cnt_d        = '0;
					item_done    = 1'b1;
				end else if (!question && cnt_d >= 16'(dmrp_pkg::RECORD_BYTES)) begin
					rec_v                = 1'b1;
					rec_res.kind         = {1'b0, sec_q[1:0]};
					rec_res.time_to_live = ttl_d;
					rec_res.rdata_length = len_d;
					cnt_d                = len_d;
					if (len_d == 16'd0) begin
						item_done = 1'b1;
					end else begin
						phase_d = dmrp_pkg::PH_RDATA;
					end
				end
			end
			dmrp_pkg::PH_RDATA: begin
				if (cnt_q != 16'd0) begin
					cnt_d = cnt_q - 16'd1;
				end
				if (cnt_d == 16'd0) begin
					item_done = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (item_done && !sec_d[2] && counts_d[sec_d[1:0]] != 16'd0) begin
			counts_d[sec_d[1:0]] = counts_d[sec_d[1:0]] - 16'd1;
		end

		// Next section that still holds items, at or after the current one.
		if (item_done || seek) begin
			for (int i = 3; i >= 0; i--) begin
				if (3'(i) >= sec_d && counts_d[i] != 16'd0) begin
					sec_n = 3'(i);
				end
			end
			if (sec_d[2]) begin
				sec_n = sec_d;
			end
			sec_d   = sec_n;
			phase_d = sec_n[2] ? dmrp_pkg::PH_DONE : dmrp_pkg::PH_NAMELEN;
		end

		if (msg.end_of_message) begin
			end_res.kind          = (phase_d == dmrp_pkg::PH_DONE) ?
			                        dmrp_pkg::KIND_END_OK : dmrp_pkg::KIND_END_TRUNC;
			end_res.message_id    = id_d;
			end_res.message_flags = flags_d;
			end_res.last          = 1'b1;
			phase_d  = dmrp_pkg::PH_HEADER;
			cnt_d    = '0;
			sec_d    = '0;
			for (int i = 0; i < 4; i++) begin
				counts_d[i] = '0;
			end
			id_d     = '0;
			flags_d  = '0;
			type_d   = '0;
			class_d  = '0;
			ttl_d    = '0;
			len_d    = '0;
		end
	end

	// The record result always leaves ahead of the end result.
	assign push0_v = accept && (rec_v || msg.end_of_message);
	assign push1_v = accept && rec_v && msg.end_of_message;
	assign push0   = rec_v ? rec_res : end_res;
	assign push1   = end_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dmrp_pkg::PH_HEADER;
			cnt_q   <= '0;
			sec_q   <= '0;
			for (int i = 0; i < 4; i++) begin
				counts_q[i] <= '0;
			end
			id_q    <= '0;
			flags_q <= '0;
			type_q  <= '0;
			class_q <= '0;
			ttl_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			sec_q    <= sec_d;
			counts_q <= counts_d;
			id_q     <= id_d;
			flags_q  <= flags_d;
			type_q   <= type_d;
			class_q  <= class_d;
			ttl_q    <= ttl_d;
			len_q    <= len_d;
		end
	end

	assign pop       = res_valid && !res_stall;
	assign res_valid = (count_q != '0);
	assign res       = fifo_q[rd_q];
	assign msg_stall = (count_q > dmrp_pkg::QCNT_W'(dmrp_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push0_v) begin
			fifo_q[wr_q] <= push0;
		end
		if (push1_v) begin
			fifo_q[wr_q + dmrp_pkg::QPTR_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + dmrp_pkg::QPTR_W'(push0_v) + dmrp_pkg::QPTR_W'(push1_v);
			rd_q    <= rd_q + dmrp_pkg::QPTR_W'(pop);
			count_q <= count_q + dmrp_pkg::QCNT_W'(push0_v) + dmrp_pkg::QCNT_W'(push1_v)
			           - dmrp_pkg::QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire
